/* rtl/core/rpc_pkg.sv */
// Package for the point rotation block: widths, CORDIC constants, the arctangent table.
// Has no dependencies. All other files in rtl/core import it.
package rpc_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int COORD_WIDTH_DEF   = 32;

  // CORDIC datapath widths: x and y in Q2.30 with headroom, z in 2^-32 turn.
  localparam int XW = 34;
  localparam int ZW = 34;
  localparam int QW = XW + 1;

  localparam logic signed [XW-1:0] CORDIC_GAIN = XW'(32'h26DD3B6A);

  // Quadrant codes of the effective angle.
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  // Side data carried along the cell chain: quadrant, dx, dy, cx, cy.
  function automatic int side_width(input int cw);
    return 2 + 2 * (cw + 1) + 2 * cw;
  endfunction

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] v;
    unique case (idx)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      5'd31: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/rpc_prep.sv */
// Input stage: effective angle, quadrant split, residual angle and point offsets.
// Depends on rpc_pkg.
module rpc_prep #(
  parameter int CW = rpc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    vld_i,
  input  logic                                    mode_i,
  input  logic signed [CW-1:0]                    point_x_i,
  input  logic signed [CW-1:0]                    point_y_i,
  input  logic signed [CW-1:0]                    center_x_i,
  input  logic signed [CW-1:0]                    center_y_i,
  input  logic [15:0]                             angle_i,
  output logic                                    vld_o,
  output logic signed [rpc_pkg::ZW-1:0]           z_o,
  output logic [rpc_pkg::side_width(CW)-1:0]      side_o
);
  import rpc_pkg::*;

  localparam int DW     = CW + 1;
  localparam int SIDE_W = side_width(CW);

  logic [15:0]              eff_angle;
  logic [15:0]              angle_off;
  logic [1:0]               quad;
  logic [15:0]              resid;
  logic signed [DW-1:0]     dx;
  logic signed [DW-1:0]     dy;
  logic                     vld_r;
  logic signed [ZW-1:0]     z_r, z_nxt;
  logic [SIDE_W-1:0]        side_r, side_nxt;

  always_comb begin
    eff_angle = mode_i ? 16'(16'd0 - angle_i) : angle_i;
    angle_off = eff_angle + 16'h2000;
    quad      = angle_off[15:14];
    // Residual lands in -8192..8191 once the quadrant is taken out.
    resid     = eff_angle - {quad, 14'd0};
    z_nxt     = {{(ZW-32){resid[15]}}, resid, 16'd0};
    dx        = DW'(point_x_i) - DW'(center_x_i);
    dy        = DW'(point_y_i) - DW'(center_y_i);
    side_nxt  = {quad, dx, dy, center_x_i, center_y_i};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    z_r    <= z_nxt;
    side_r <= side_nxt;
  end

  assign vld_o  = vld_r;
  assign z_o    = z_r;
  assign side_o = side_r;

endmodule

/* rtl/core/rpc_cordic_cell.sv */
// One CORDIC rotation cell: a micro-rotation by atan(2^-STAGE) and a register.
// Depends on rpc_pkg.
module rpc_cordic_cell #(
  parameter int STAGE  = 0,
  parameter int SIDE_W = rpc_pkg::side_width(rpc_pkg::COORD_WIDTH_DEF)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           vld_i,
  input  logic signed [rpc_pkg::XW-1:0]  x_i,
  input  logic signed [rpc_pkg::XW-1:0]  y_i,
  input  logic signed [rpc_pkg::ZW-1:0]  z_i,
  input  logic [SIDE_W-1:0]              side_i,
  output logic                           vld_o,
  output logic signed [rpc_pkg::XW-1:0]  x_o,
  output logic signed [rpc_pkg::XW-1:0]  y_o,
  output logic signed [rpc_pkg::ZW-1:0]  z_o,
  output logic [SIDE_W-1:0]              side_o
);
  import rpc_pkg::*;

  logic signed [XW-1:0] xs;
  logic signed [XW-1:0] ys;
  logic signed [ZW-1:0] step_angle;
  logic                 vld_r;
  logic signed [XW-1:0] x_r, x_nxt;
  logic signed [XW-1:0] y_r, y_nxt;
  logic signed [ZW-1:0] z_r, z_nxt;
  logic [SIDE_W-1:0]    side_r;

  always_comb begin
    xs         = x_i >>> STAGE;
    ys         = y_i >>> STAGE;
    step_angle = signed'(ZW'(atan_turn(5'(STAGE))));
    if (!z_i[ZW-1]) begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - step_angle;
    end else begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + step_angle;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    z_r    <= z_nxt;
    side_r <= side_i;
  end

  assign vld_o  = vld_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;
  assign side_o = side_r;

endmodule

/* rtl/core/rpc_post.sv */
// Back end: quadrant fix-up, trig scaling, products, rounding, center add, saturation.
// Four register stages. Depends on rpc_pkg.
module rpc_post #(
  parameter int CW = rpc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                vld_i,
  input  logic signed [rpc_pkg::XW-1:0]       x_i,
  input  logic signed [rpc_pkg::XW-1:0]       y_i,
  input  logic [rpc_pkg::side_width(CW)-1:0]  side_i,
  output logic                                vld_o,
  output logic signed [CW-1:0]                result_x_o,
  output logic signed [CW-1:0]                result_y_o
);
  import rpc_pkg::*;

  localparam int DW     = CW + 1;
  localparam int SIDE_W = side_width(CW);
  localparam int TF     = 60 - CW;     // fraction bits of the scaled sine and cosine
  localparam int K      = CW - 30;     // shift from Q2.30 to Q(TF)
  localparam int TW     = 67 - CW;     // width of the scaled sine and cosine
  localparam int PW     = DW + TW;
  localparam int SW     = PW + 2;
  localparam int VW     = SW - TF + 1;

  localparam logic signed [SW-1:0] ROUND_C = SW'(64'd1 << (TF - 1));
  localparam logic signed [VW-1:0] SAT_HI  = VW'({1'b0, {(CW-1){1'b1}}});
  localparam logic signed [VW-1:0] SAT_LO  = ~SAT_HI;

  // Unpacked side data.
  logic [1:0]            quad;
  logic signed [DW-1:0]  dx_in, dy_in;
  logic signed [CW-1:0]  cx_in, cy_in;
  logic signed [QW-1:0]  cq, sq;
  logic signed [TW-1:0]  ct, st;

  // Stage 1: scaled trig values.
  logic                  vld1_r;
  logic signed [TW-1:0]  c1_r, s1_r;
  logic signed [DW-1:0]  dx1_r, dy1_r;
  logic signed [CW-1:0]  cx1_r, cy1_r;
  // Stage 2: products.
  logic                  vld2_r;
  logic signed [PW-1:0]  pxc_r, pys_r, pxs_r, pyc_r;
  logic signed [CW-1:0]  cx2_r, cy2_r;
  // Stage 3: rounded sums.
  logic                  vld3_r;
  logic signed [SW-1:0]  sx_r, sx_nxt, sy_r, sy_nxt;
  logic signed [CW-1:0]  cx3_r, cy3_r;
  // Stage 4: result register.
  logic                  vld4_r;
  logic signed [VW-1:0]  vx, vy;
  logic signed [CW-1:0]  rx_r, rx_nxt, ry_r, ry_nxt;

  assign cy_in = side_i[CW-1:0];
  assign cx_in = side_i[2*CW-1:CW];
  assign dy_in = side_i[2*CW+DW-1:2*CW];
  assign dx_in = side_i[2*CW+2*DW-1:2*CW+DW];
  assign quad  = side_i[SIDE_W-1:SIDE_W-2];

  always_comb begin
    unique case (quad)
      QUAD_0: begin
        cq = QW'(x_i);
        sq = QW'(y_i);
      end
      QUAD_1: begin
        cq = -QW'(y_i);
        sq = QW'(x_i);
      end
      QUAD_2: begin
        cq = -QW'(x_i);
        sq = -QW'(y_i);
      end
      QUAD_3: begin
        cq = QW'(y_i);
        sq = -QW'(x_i);
      end
    endcase
  end

  // Rescaling from Q2.30 to Q(TF): round half up when narrowing, exact when widening.
  if (K > 0) begin : g_narrow
    logic signed [QW:0] c_rnd, s_rnd;
    always_comb begin
      c_rnd = (QW+1)'(cq) + (QW+1)'(64'd1 << (K - 1));
      s_rnd = (QW+1)'(sq) + (QW+1)'(64'd1 << (K - 1));
      ct    = TW'(c_rnd >>> K);
      st    = TW'(s_rnd >>> K);
    end
  end else if (K < 0) begin : g_widen
    always_comb begin
      ct = TW'(cq) <<< (-K);
      st = TW'(sq) <<< (-K);
    end
  end else begin : g_same
    always_comb begin
      ct = TW'(cq);
      st = TW'(sq);
    end
  end

  always_comb begin
    sx_nxt = SW'(pxc_r) - SW'(pys_r) + ROUND_C;
    sy_nxt = SW'(pxs_r) + SW'(pyc_r) + ROUND_C;
    vx     = VW'(sx_r >>> TF) + VW'(cx3_r);
    vy     = VW'(sy_r >>> TF) + VW'(cy3_r);
    priority if (vx > SAT_HI) begin
      rx_nxt = SAT_HI[CW-1:0];
    end else if (vx < SAT_LO) begin
      rx_nxt = SAT_LO[CW-1:0];
    end else begin
      rx_nxt = vx[CW-1:0];
    end
    priority if (vy > SAT_HI) begin
      ry_nxt = SAT_HI[CW-1:0];
    end else if (vy < SAT_LO) begin
      ry_nxt = SAT_LO[CW-1:0];
    end else begin
      ry_nxt = vy[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld2_r <= 1'b0;
      vld3_r <= 1'b0;
      vld4_r <= 1'b0;
    end else begin
      vld1_r <= vld_i;
      vld2_r <= vld1_r;
      vld3_r <= vld2_r;
      vld4_r <= vld3_r;
    end
  end

  always_ff @(posedge clk) begin
    c1_r  <= ct;
    s1_r  <= st;
    dx1_r <= dx_in;
    dy1_r <= dy_in;
    cx1_r <= cx_in;
    cy1_r <= cy_in;

    pxc_r <= PW'(dx1_r) * PW'(c1_r);
    pys_r <= PW'(dy1_r) * PW'(s1_r);
    pxs_r <= PW'(dx1_r) * PW'(s1_r);
    pyc_r <= PW'(dy1_r) * PW'(c1_r);
    cx2_r <= cx1_r;
    cy2_r <= cy1_r;

    sx_r  <= sx_nxt;
    sy_r  <= sy_nxt;
    cx3_r <= cx2_r;
    cy3_r <= cy2_r;

    rx_r  <= rx_nxt;
    ry_r  <= ry_nxt;
  end

  assign vld_o      = vld4_r;
  assign result_x_o = rx_r;
  assign result_y_o = ry_r;

endmodule

/* rtl/core/rotate_point_about_center.sv */
// Rotation of a point about a center by a binary angle, CORDIC based.
// Depends on rpc_pkg, rpc_prep, rpc_cordic_cell and rpc_post.
//
// Usage:
//   An item is taken at a rising edge with start high and busy low. It carries a
//   mode bit (1 rotates by the negated angle), a point and a center in signed
//   Q16.16 and a 16-bit angle with 65536 units to a full turn.
//   The item passes one input register, one CORDIC cell per stage, and four
//   back-end stages (trig scaling, products, rounded sums, result); then
//   out_strobe is high for one cycle with the rotated point on out_result_x
//   and out_result_y, saturated to the coordinate range.
//   The pipeline takes a new item every cycle; items come out in order.
//   busy is low at all times out of reset, so back-to-back starts are fine.
//   The receiver has no way to stall the result channel and needs none.
//   Reset clears the valid flags of all stages; items in flight are dropped and
//   busy stays high while rst_n is low.
module rotate_point_about_center #(
  parameter int CORDIC_STAGES = rpc_pkg::CORDIC_STAGES_DEF,
  parameter int COORD_WIDTH   = rpc_pkg::COORD_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_mode,
  input  logic signed [COORD_WIDTH-1:0] in_point_x,
  input  logic signed [COORD_WIDTH-1:0] in_point_y,
  input  logic signed [COORD_WIDTH-1:0] in_center_x,
  input  logic signed [COORD_WIDTH-1:0] in_center_y,
  input  logic [15:0]                   in_angle,
  output logic                          out_strobe,
  output logic signed [COORD_WIDTH-1:0] out_result_x,
  output logic signed [COORD_WIDTH-1:0] out_result_y
);
  import rpc_pkg::*;

  localparam int SIDE_W  = side_width(COORD_WIDTH);
  localparam int LATENCY = CORDIC_STAGES + 5;

  logic                 accept;
  logic                 vld_chain  [0:CORDIC_STAGES];
  logic signed [XW-1:0] x_chain    [0:CORDIC_STAGES];
  logic signed [XW-1:0] y_chain    [0:CORDIC_STAGES];
  logic signed [ZW-1:0] z_chain    [0:CORDIC_STAGES];
  logic [SIDE_W-1:0]    side_chain [0:CORDIC_STAGES];

  assign busy   = ~rst_n;
  assign accept = start & ~busy;

  rpc_prep #(
    .CW (COORD_WIDTH)
  ) u_prep (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld_i      (accept),
    .mode_i     (in_mode),
    .point_x_i  (in_point_x),
    .point_y_i  (in_point_y),
    .center_x_i (in_center_x),
    .center_y_i (in_center_y),
    .angle_i    (in_angle),
    .vld_o      (vld_chain[0]),
    .z_o        (z_chain[0]),
    .side_o     (side_chain[0])
  );

  // The rotation starts from the gain-compensated unit vector.
  assign x_chain[0] = CORDIC_GAIN;
  assign y_chain[0] = '0;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    rpc_cordic_cell #(
      .STAGE  (i),
      .SIDE_W (SIDE_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .vld_i  (vld_chain[i]),
      .x_i    (x_chain[i]),
      .y_i    (y_chain[i]),
      .z_i    (z_chain[i]),
      .side_i (side_chain[i]),
      .vld_o  (vld_chain[i+1]),
      .x_o    (x_chain[i+1]),
      .y_o    (y_chain[i+1]),
      .z_o    (z_chain[i+1]),
      .side_o (side_chain[i+1])
    );
  end

  rpc_post #(
    .CW (COORD_WIDTH)
  ) u_post (
    .clk        (clk),
    .rst_n      (rst_n),
    .vld_i      (vld_chain[CORDIC_STAGES]),
    .x_i        (x_chain[CORDIC_STAGES]),
    .y_i        (y_chain[CORDIC_STAGES]),
    .side_i     (side_chain[CORDIC_STAGES]),
    .vld_o      (out_strobe),
    .result_x_o (out_result_x),
    .result_y_o (out_result_y)
  );

`ifndef NO_ASSERTIONS
  // Every result traces back to an item taken the pipeline depth earlier.
  a_strobe_has_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(accept, LATENCY))
    else $error("result strobe without a matching item");

  // Every item taken produces its result after the pipeline depth.
  a_item_gives_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##LATENCY out_strobe)
    else $error("item lost in the pipeline");
`endif

endmodule

/* test/rotate_point_about_center_test.sv */
// Self-checking testbench for rotate_point_about_center: directed and random items.
// It predicts each rotated point with its own CORDIC model and checks every result.
// Depends on rpc_pkg and the rotate_point_about_center RTL.
`timescale 1ns / 100ps

module rotate_point_about_center_test;

  import rpc_pkg::*;

  localparam int N_STAGES   = CORDIC_STAGES_DEF;
  localparam int COORD_W    = COORD_WIDTH_DEF;
  localparam int TRIG_FRAC  = 60 - COORD_W;
  localparam int TRIG_SHIFT = 30 - TRIG_FRAC;
  localparam int LATENCY    = N_STAGES + 5;
  localparam int IDLE_LIMIT = 2000;
  localparam int N_RANDOM   = 550;
  localparam int MAX_PRINTS = 50;

  localparam longint CORDIC_K = 64'h26DD3B6A;
  localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
  localparam logic signed [COORD_W-1:0] ONE   = COORD_W'(32'h0001_0000);

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

  logic                        clk;
  logic                        rst_n;
  logic                        start;
  logic                        busy;
  logic                        in_mode;
  logic signed [COORD_W-1:0]   in_point_x;
  logic signed [COORD_W-1:0]   in_point_y;
  logic signed [COORD_W-1:0]   in_center_x;
  logic signed [COORD_W-1:0]   in_center_y;
  logic [15:0]                 in_angle;
  logic                        out_strobe;
  logic signed [COORD_W-1:0]   out_result_x;
  logic signed [COORD_W-1:0]   out_result_y;

  point_t pending_points[$];
  int     error_count;
  int     items_sent;
  int     results_checked;
  int     idle_cycles;
  bit     burst_mode;

  rotate_point_about_center u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_mode      (in_mode),
    .in_point_x   (in_point_x),
    .in_point_y   (in_point_y),
    .in_center_x  (in_center_x),
    .in_center_y  (in_center_y),
    .in_angle     (in_angle),
    .out_strobe   (out_strobe),
    .out_result_x (out_result_x),
    .out_result_y (out_result_y)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  initial begin
    clk         = 1'b0;
    start       <= 1'b0;
    in_mode     <= 1'b0;
    in_point_x  <= '0;
    in_point_y  <= '0;
    in_center_x <= '0;
    in_center_y <= '0;
    in_angle    <= '0;
  end

  // atan(2^-i) in units of 2^-32 turn.
  function automatic longint atan_of_stage(input int i);
    case (i)
      0:  return 64'h20000000;
      1:  return 64'h12E4051E;
      2:  return 64'h09FB385B;
      3:  return 64'h051111D4;
      4:  return 64'h028B0D43;
      5:  return 64'h0145D7E1;
      6:  return 64'h00A2F61E;
      7:  return 64'h00517C55;
      8:  return 64'h0028BE53;
      9:  return 64'h00145F2F;
      10: return 64'h000A2F98;
      11: return 64'h000517CC;
      12: return 64'h00028BE6;
      13: return 64'h000145F3;
      14: return 64'h0000A2FA;
      15: return 64'h0000517D;
      16: return 64'h000028BE;
      17: return 64'h0000145F;
      18: return 64'h00000A30;
      19: return 64'h00000518;
      20: return 64'h0000028C;
      21: return 64'h00000146;
      22: return 64'h000000A3;
      23: return 64'h00000051;
      24: return 64'h00000029;
      25: return 64'h00000014;
      26: return 64'h0000000A;
      27: return 64'h00000005;
      28: return 64'h00000003;
      29: return 64'h00000001;
      30: return 64'h00000001;
      default: return 64'h0;
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] round_and_clamp(input longint acc,
                                                                input longint center);
    longint v;
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (COORD_W - 1)) - 1;
    lo = -(longint'(1) <<< (COORD_W - 1));
    v = ((acc + (longint'(1) <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC) + center;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return COORD_W'(v);
  endfunction

  function automatic point_t predict_rotation(input logic m,
                                              input logic signed [COORD_W-1:0] px,
                                              input logic signed [COORD_W-1:0] py,
                                              input logic signed [COORD_W-1:0] cx,
                                              input logic signed [COORD_W-1:0] cy,
                                              input logic [15:0] ang);
    logic [15:0] eff;
    logic [15:0] shifted;
    logic [15:0] resid;
    logic [1:0]  quad;
    longint      x, y, z, xs, ys, c, s, t, dx, dy;
    int          i;
    point_t      res;
    eff     = m ? 16'(16'd0 - ang) : ang;
    // The quadrant is picked so that the residual angle stays within an eighth turn.
    shifted = eff + 16'h2000;
    quad    = shifted[15:14];
    resid   = eff - {quad, 14'd0};
    x = CORDIC_K;
    y = 0;
    z = longint'($signed(resid)) * 65536;
    for (i = 0; i < N_STAGES && i < 32; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - atan_of_stage(i);
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + atan_of_stage(i);
      end
    end
    c = x;
    s = y;
    case (quad)
      QUAD_1: begin
        t = c; c = -s; s = t;
      end
      QUAD_2: begin
        c = -c; s = -s;
      end
      QUAD_3: begin
        t = c; c = s; s = -t;
      end
      default: ;
    endcase
    c  = (c + (longint'(1) <<< (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
    s  = (s + (longint'(1) <<< (TRIG_SHIFT - 1))) >>> TRIG_SHIFT;
    dx = longint'(px) - longint'(cx);
    dy = longint'(py) - longint'(cy);
    res.x = round_and_clamp(dx * c - dy * s, longint'(cx));
    res.y = round_and_clamp(dx * s + dy * c, longint'(cy));
    return res;
  endfunction

  task automatic report_error(input string msg);
    if (error_count < MAX_PRINTS) $display("ERROR at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic reset_block();
    rst_n <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
  endtask

  // Drives one item and holds it until the block takes it; returns at the accepting edge.
  task automatic send_item(input logic m,
                           input logic signed [COORD_W-1:0] px,
                           input logic signed [COORD_W-1:0] py,
                           input logic signed [COORD_W-1:0] cx,
                           input logic signed [COORD_W-1:0] cy,
                           input logic [15:0] ang);
    bit taken;
    start       <= 1'b1;
    in_mode     <= m;
    in_point_x  <= px;
    in_point_y  <= py;
    in_center_x <= cx;
    in_center_y <= cy;
    in_angle    <= ang;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !busy;
      @(posedge clk);
    end
    pending_points.push_back(predict_rotation(m, px, py, cx, cy, ang));
    items_sent++;
  endtask

  task automatic pause_between();
    int roll;
    int gap;
    roll = $urandom_range(0, 99);
    if (burst_mode || roll < 50) gap = 0;
    else if (roll < 85) gap = $urandom_range(1, 3);
    else if (roll < 97) gap = $urandom_range(4, 10);
    else gap = $urandom_range(20, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord();
    case ($urandom_range(0, 5))
      0, 1: return COORD_W'($urandom);
      2: return COORD_W'(int'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000);
      3: return C_MAX - COORD_W'($urandom_range(0, 255));
      4: return C_MIN + COORD_W'($urandom_range(0, 255));
      default: return COORD_W'(int'($urandom_range(0, 32'h2000_0000)) - 32'h1000_0000);
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    logic [15:0] edges [14];
    edges = '{16'd0, 16'd8191, 16'd8192, 16'd16383, 16'd16384, 16'd24575, 16'd24576,
              16'd32768, 16'd40959, 16'd40960, 16'd49152, 16'd57343, 16'd57344,
              16'd65535};
    if ($urandom_range(0, 9) < 3) return edges[$urandom_range(0, 13)];
    return 16'($urandom);
  endfunction

  task automatic test_directed();
    logic [15:0] angles [8];
    int k;
    int m;
    angles = '{16'd0, 16'd8191, 16'd8192, 16'd16384, 16'd24576, 16'd32768, 16'd49152,
               16'd65535};
    for (m = 0; m < 2; m++) begin
      for (k = 0; k < 8; k++) begin
        send_item(m[0], ONE, ONE >>> 1, ONE <<< 1, -(ONE * 3), angles[k]);
        pause_between();
      end
    end
    // Items with coordinates at the ends of the range; some drive the outputs into saturation.
    send_item(1'b0, C_MAX, C_MAX, C_MIN, C_MIN, 16'd32768);
    pause_between();
    send_item(1'b0, C_MIN, C_MIN, C_MAX, C_MAX, 16'd16384);
    pause_between();
    send_item(1'b0, C_MAX, C_MIN, '0, '0, 16'd0);
    pause_between();
    send_item(1'b1, C_MAX, C_MAX, C_MAX, C_MAX, 16'd12345);
    pause_between();
    send_item(1'b0, C_MIN, C_MIN, C_MIN, C_MIN, 16'd54321);
    pause_between();
    send_item(1'b1, C_MAX, '0, C_MIN, '0, 16'd8192);
    pause_between();
  endtask

  task automatic test_random_rotations();
    int n;
    logic signed [COORD_W-1:0] cx, cy, px, py;
    for (n = 0; n < N_RANDOM; n++) begin
      if (n % 50 == 0) burst_mode = ($urandom_range(0, 3) == 0);
      cx = pick_coord();
      cy = pick_coord();
      if ($urandom_range(0, 9) < 6) begin
        // Point close to its center, the usual geometric case.
        px = cx + COORD_W'(int'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000);
        py = cy + COORD_W'(int'($urandom_range(0, 32'h0100_0000)) - 32'h0080_0000);
      end else begin
        px = pick_coord();
        py = pick_coord();
      end
      send_item(1'($urandom), px, py, cx, cy, pick_angle());
      pause_between();
    end
    burst_mode = 1'b0;
  endtask

  always @(negedge clk) begin
    point_t want;
    if (rst_n && out_strobe) begin
      if (pending_points.size() == 0) begin
        report_error($sformatf("result with no item pending: x=%h y=%h",
                               out_result_x, out_result_y));
      end else begin
        want = pending_points.pop_front();
        if (out_result_x !== want.x)
          report_error($sformatf("result_x got %h expected %h", out_result_x, want.x));
        if (out_result_y !== want.y)
          report_error($sformatf("result_y got %h expected %h", out_result_y, want.y));
        results_checked++;
      end
    end
  end

  // Ends the run if neither channel moves for too long.
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(negedge clk);
      if ((start && !busy) || out_strobe) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("Watchdog expired after %0d idle cycles", IDLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    error_count     = 0;
    items_sent      = 0;
    results_checked = 0;
    burst_mode      = 1'b0;
    reset_block();
    test_directed();
    test_random_rotations();
    start <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    $display("Sent %0d items (quadrant edges, saturation, both modes) and checked %0d results.",
             items_sent, results_checked);
    $display("Mismatches found: %0d", error_count);
    if (error_count == 0 && pending_points.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
